FILE: design/tmhc_pkg.sv
package tmhc_pkg;

  // field widths
  localparam int unsigned RAW_W   = 12;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SCR_W   = 9;
  localparam int unsigned ACT_W   = 4;
  localparam int unsigned IDX_W   = 2;

  // internal widths, sized for screen limits up to 4095
  localparam int unsigned COORD_W = 12;
  localparam int unsigned DIFF_W  = 14;  // magnitude of raw - bound and of span
  localparam int unsigned QUO_W   = 13;  // quotient bits kept; more means clamp
  localparam int unsigned PROD_W  = DIFF_W + COORD_W;
  localparam int unsigned CNT_W   = $clog2(QUO_W);

  // parameter defaults
  localparam int unsigned DEF_LOCKOUT_MS   = 180;
  localparam int unsigned DEF_SCREEN_X_MAX = 479;
  localparam int unsigned DEF_SCREEN_Y_MAX = 319;

  // register reset values
  localparam logic [CFG_W-1:0] RST_X_LEFT   = CFG_W'(0);
  localparam logic [CFG_W-1:0] RST_X_RIGHT  = CFG_W'(4095);
  localparam logic [CFG_W-1:0] RST_Y_TOP    = CFG_W'(0);
  localparam logic [CFG_W-1:0] RST_Y_BOTTOM = CFG_W'(4095);

  // touch zones
  localparam logic [COORD_W-1:0] STATUS_ROW   = COORD_W'(266);
  localparam logic [COORD_W-1:0] STATUS_COL_A = COORD_W'(112);
  localparam logic [COORD_W-1:0] STATUS_COL_B = COORD_W'(336);
  localparam logic [COORD_W-1:0] HEADER_ROW   = COORD_W'(80);
  localparam logic [COORD_W-1:0] HEADER_COL   = COORD_W'(355);
  localparam logic [COORD_W-1:0] BAND_ROW_LO  = COORD_W'(250 - 16);
  localparam logic [COORD_W-1:0] BAND_ROW_HI  = COORD_W'(319);
  localparam logic [COORD_W-1:0] RANGE_COL_A  = COORD_W'(120);
  localparam logic [COORD_W-1:0] RANGE_COL_B  = COORD_W'(240);
  localparam logic [COORD_W-1:0] RANGE_COL_C  = COORD_W'(360);

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE      = 4'd0,
    ACT_DASHBOARD = 4'd1,
    ACT_CALIBRATE = 4'd2,
    ACT_CLK_FMT   = 4'd3,
    ACT_STATUS    = 4'd4,
    ACT_RANGE_3H  = 4'd5,
    ACT_RANGE_6H  = 4'd6,
    ACT_RANGE_12H = 4'd7,
    ACT_RANGE_24H = 4'd8
  } action_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_X_LEFT   = 2'd0,
    CFG_X_RIGHT  = 2'd1,
    CFG_Y_TOP    = 2'd2,
    CFG_Y_BOTTOM = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              touch_down;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [TIME_W-1:0] time_ms;
    logic              on_status_screen;
  } sample_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             press_accepted;
    logic [SCR_W-1:0] screen_x;
    logic [SCR_W-1:0] screen_y;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [RAW_W-1:0] raw;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
  } lane_cmd_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] value;
  } lane_res_t;

endpackage

FILE: design/tmhc_if.sv
interface tmhc_sample_if;
  import tmhc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tmhc_result_if;
  import tmhc_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/tmhc_axis.sv
module tmhc_axis #(
  parameter int unsigned TOP = tmhc_pkg::DEF_SCREEN_X_MAX
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmhc_pkg::lane_cmd_t cmd_i,
  output tmhc_pkg::lane_res_t res_o
);
  import tmhc_pkg::*;

  localparam logic [COORD_W-1:0] TopC = COORD_W'(TOP);
  localparam int unsigned        SW   = DIFF_W + 2;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_MUL  = 5'b00010,
    PH_CHK  = 5'b00100,
    PH_DIV  = 5'b01000,
    PH_DONE = 5'b10000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic                neg_q, zero_q, ovf_q;
  logic [DIFF_W-1:0]   nmag_q, dmag_q, rem_q;
  logic [PROD_W-1:0]   prod_q;
  logic [QUO_W-1:0]    sh_q;
  logic [CNT_W-1:0]    cnt_q;

  logic signed [SW-1:0] num_s, den_s;
  logic [SW-1:0]        num_abs, den_abs;
  logic [DIFF_W:0]      trial, trial_sub;
  logic                 ge;

  // signed differences of the raw sample and the span against the low bound
  assign num_s   = $signed({{(SW-RAW_W){1'b0}}, cmd_i.raw})
                 - $signed({{(SW-CFG_W){cmd_i.lo[CFG_W-1]}}, cmd_i.lo});
  assign den_s   = $signed({{(SW-CFG_W){cmd_i.hi[CFG_W-1]}}, cmd_i.hi})
                 - $signed({{(SW-CFG_W){cmd_i.lo[CFG_W-1]}}, cmd_i.lo});
  assign num_abs = num_s[SW-1] ? SW'(-num_s) : SW'(num_s);
  assign den_abs = den_s[SW-1] ? SW'(-den_s) : SW'(den_s);

  // restoring division step, one quotient bit a cycle
  assign trial     = {rem_q, sh_q[QUO_W-1]};
  assign ge        = trial >= {1'b0, dmag_q};
  assign trial_sub = trial - {1'b0, dmag_q};

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: if (cmd_i.start) phase_d = PH_MUL;
      PH_MUL:  phase_d = PH_CHK;
      PH_CHK:  phase_d = PH_DIV;
      PH_DIV:  if (cnt_q == '0) phase_d = PH_DONE;
      PH_DONE: phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      PH_IDLE: begin
        nmag_q <= num_abs[DIFF_W-1:0];
        dmag_q <= den_abs[DIFF_W-1:0];
        neg_q  <= num_s[SW-1] ^ den_s[SW-1];
        zero_q <= (den_s == '0);
      end
      PH_MUL: prod_q <= PROD_W'(nmag_q) * PROD_W'(TopC);
      PH_CHK: begin
        // quotient of 2^QUO_W or more is beyond any screen limit
        ovf_q <= {1'b0, prod_q} >= {dmag_q, {QUO_W{1'b0}}};
        rem_q <= DIFF_W'(prod_q[PROD_W-1:QUO_W]);
        sh_q  <= prod_q[QUO_W-1:0];
        cnt_q <= CNT_W'(QUO_W - 1);
      end
      PH_DIV: begin
        rem_q <= ge ? trial_sub[DIFF_W-1:0] : trial[DIFF_W-1:0];
        sh_q  <= {sh_q[QUO_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.done = (phase_q == PH_DONE);
    if (zero_q || neg_q) begin
      res_o.value = '0;
    end else if (ovf_q || (sh_q > QUO_W'(TopC))) begin
      res_o.value = TopC;
    end else begin
      res_o.value = sh_q[COORD_W-1:0];
    end
  end

endmodule

FILE: design/tmhc_zone.sv
module tmhc_zone (
  input  logic [tmhc_pkg::COORD_W-1:0] x_i,
  input  logic [tmhc_pkg::COORD_W-1:0] y_i,
  input  logic                         status_i,
  output tmhc_pkg::action_e            action_o
);
  import tmhc_pkg::*;

  always_comb begin
    action_o = ACT_NONE;
    if (status_i) begin
      if (y_i >= STATUS_ROW) begin
        if (x_i < STATUS_COL_A)      action_o = ACT_DASHBOARD;
        else if (x_i < STATUS_COL_B) action_o = ACT_CALIBRATE;
        else                         action_o = ACT_CLK_FMT;
      end
    end else if (y_i <= HEADER_ROW && x_i >= HEADER_COL) begin
      action_o = ACT_STATUS;
    end else if (y_i >= BAND_ROW_LO && y_i <= BAND_ROW_HI) begin
      if (x_i < RANGE_COL_A)      action_o = ACT_RANGE_3H;
      else if (x_i < RANGE_COL_B) action_o = ACT_RANGE_6H;
      else if (x_i < RANGE_COL_C) action_o = ACT_RANGE_12H;
      else                        action_o = ACT_RANGE_24H;
    end
  end

endmodule

FILE: design/touch_map_and_hit_classifier.sv
// Channel   | Dir | Payload                                       | Handshake
// ----------+-----+-----------------------------------------------+------------
// sample_i  | in  | touch_down, raw_x, raw_y, time_ms, status flag | valid/ready
// result_o  | out | action, press_accepted, screen_x, screen_y     | valid/ready
// cfg_*_i   | in  | register index, 14-bit calibration bound       | write enable
//
// A new press passes through multiply, range check, 13 divider steps,
// write-back and emit before it loads the result register. Both axes run in
// parallel lanes, so the bit-serial divider sets how long a press takes. Any
// other sample goes straight to the emit state and loads the result from
// there. One request is in flight at a time; the next is taken as soon as the
// previous result sits in the output register. Reset is async, active low,
// and restores the calibration bounds. A stalled result holds the block in
// its emit state without losing anything.
module touch_map_and_hit_classifier #(
  parameter int unsigned LOCKOUT_MS   = tmhc_pkg::DEF_LOCKOUT_MS,
  parameter int unsigned SCREEN_X_MAX = tmhc_pkg::DEF_SCREEN_X_MAX,
  parameter int unsigned SCREEN_Y_MAX = tmhc_pkg::DEF_SCREEN_Y_MAX
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tmhc_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [tmhc_pkg::CFG_W-1:0] cfg_data_i,
  tmhc_sample_if.sink                sample_i,
  tmhc_result_if.source              result_o
);
  import tmhc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // calibration bounds
  logic [CFG_W-1:0] x_left_q, x_right_q, y_top_q, y_bottom_q;

  // press tracking
  logic               latched_q;
  logic [TIME_W-1:0]  last_time_q;
  logic [COORD_W-1:0] pos_x_q, pos_y_q;
  logic               new_press_q, status_q;

  // output register
  logic    res_valid_q;
  result_t res_q;

  logic      in_fire, out_free, lockout_ok, new_press;
  lane_cmd_t cmd_x, cmd_y;
  lane_res_t res_x, res_y;
  action_e   zone_act;

  assign in_fire  = sample_i.valid && sample_i.ready;
  assign out_free = !res_valid_q || result_o.ready;

  // elapsed time wraps modulo 2^32, as the timestamp does
  assign lockout_ok = (sample_i.data.time_ms - last_time_q) >= TIME_W'(LOCKOUT_MS);
  assign new_press  = sample_i.data.touch_down && !latched_q && lockout_ok;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

  always_comb begin
    cmd_x.start = in_fire && new_press;
    cmd_x.raw   = sample_i.data.raw_x;
    cmd_x.lo    = x_left_q;
    cmd_x.hi    = x_right_q;
    cmd_y.start = in_fire && new_press;
    cmd_y.raw   = sample_i.data.raw_y;
    cmd_y.lo    = y_top_q;
    cmd_y.hi    = y_bottom_q;
  end

  tmhc_axis #(.TOP(SCREEN_X_MAX)) u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_x),
    .res_o  (res_x)
  );

  tmhc_axis #(.TOP(SCREEN_Y_MAX)) u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_y),
    .res_o  (res_y)
  );

  tmhc_zone u_zone (
    .x_i      (pos_x_q),
    .y_i      (pos_y_q),
    .status_i (status_q),
    .action_o (zone_act)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = new_press ? ST_CALC : ST_EMIT;
      // both lanes share one latency, x done means y done
      ST_CALC: if (res_x.done) state_d = ST_EMIT;
      ST_EMIT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_left_q    <= RST_X_LEFT;
      x_right_q   <= RST_X_RIGHT;
      y_top_q     <= RST_Y_TOP;
      y_bottom_q  <= RST_Y_BOTTOM;
      latched_q   <= 1'b0;
      last_time_q <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      new_press_q <= 1'b0;
      status_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_X_LEFT:   x_left_q   <= cfg_data_i;
          CFG_X_RIGHT:  x_right_q  <= cfg_data_i;
          CFG_Y_TOP:    y_top_q    <= cfg_data_i;
          CFG_Y_BOTTOM: y_bottom_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (in_fire) begin
        new_press_q <= new_press;
        status_q    <= sample_i.data.on_status_screen;
        if (new_press) begin
          latched_q   <= 1'b1;
          last_time_q <= sample_i.data.time_ms;
        end else if (!sample_i.data.touch_down) begin
          latched_q   <= 1'b0;
        end
      end

      if (state_q == ST_CALC && res_x.done) begin
        pos_x_q <= res_x.value;
        pos_y_q <= res_y.value;
      end

      if (state_q == ST_EMIT && out_free) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload of the output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      res_q.action         <= new_press_q ? zone_act : ACT_NONE;
      res_q.press_accepted <= new_press_q;
      res_q.screen_x       <= pos_x_q[SCR_W-1:0];
      res_q.screen_y       <= pos_y_q[SCR_W-1:0];
    end
  end

endmodule

FILE: design/tmhc_checker.sv
module tmhc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [tmhc_pkg::ACT_W-1:0] out_action_i,
  input logic                       out_accepted_i,
  input logic [tmhc_pkg::SCR_W-1:0] out_x_i,
  input logic [tmhc_pkg::SCR_W-1:0] out_y_i
);
  import tmhc_pkg::*;

  // a pending result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a pending result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_action_i) && $stable(out_accepted_i)
      && $stable(out_x_i) && $stable(out_y_i))
    else $error("result payload changed while stalled");

  // only a new press carries an action
  a_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_accepted_i |-> out_action_i == ACT_NONE)
    else $error("action without accepted press");

  // one request in flight: no request taken on the cycle after one
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

endmodule

bind touch_map_and_hit_classifier tmhc_checker u_tmhc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .out_action_i   (result_o.data.action),
  .out_accepted_i (result_o.data.press_accepted),
  .out_x_i        (result_o.data.screen_x),
  .out_y_i        (result_o.data.screen_y)
);

FILE: sim/touch_map_and_hit_classifier_tb.sv
`timescale 1ns / 1ps

module touch_map_and_hit_classifier_tb;
  import tmhc_pkg::*;

  // Own copies of the block's fixed figures, so that the prediction does not
  // lean on the package zone constants it is meant to check.
  localparam int unsigned HOLD_OFF_MS = 180;
  localparam longint      X_SPAN      = 479;
  localparam longint      Y_SPAN      = 319;

  localparam int unsigned ST_ROW   = 266;
  localparam int unsigned ST_COL_A = 112;
  localparam int unsigned ST_COL_B = 336;
  localparam int unsigned HDR_ROW  = 80;
  localparam int unsigned HDR_COL  = 355;
  localparam int unsigned RNG_TOP  = 234;
  localparam int unsigned RNG_BOT  = 319;
  localparam int unsigned RNG_COL_A = 120;
  localparam int unsigned RNG_COL_B = 240;
  localparam int unsigned RNG_COL_C = 360;

  localparam int unsigned N_PHASES    = 9;
  localparam int unsigned RUN_ITEMS   = 70;    // minimum requests per random phase
  localparam int unsigned STALL_LIMIT = 3000;  // cycles with no handshake at all
  localparam int unsigned TAIL_CYCLES = 24;    // margin before the final check

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  tmhc_sample_if smp ();
  tmhc_result_if res ();

  touch_map_and_hit_classifier dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (smp.sink),
    .result_o   (res.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Requests waiting to be driven, and the outcomes they are due to produce.
  sample_t touch_fifo[$];
  result_t outcome_fifo[$];

  // Predicted block state: calibration bounds and press latch.
  logic [CFG_W-1:0]   cal_reg [4];
  bit                 pressed;
  logic [TIME_W-1:0]  last_press_ms;
  logic [COORD_W-1:0] held_x;
  logic [COORD_W-1:0] held_y;

  // Generator time line; press_ms tracks the last press-run touch-down.
  logic [TIME_W-1:0] gen_ms;
  logic [TIME_W-1:0] press_ms;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned n_queued;
  int unsigned n_results;
  int unsigned n_mismatch;
  int unsigned quiet_cycles;

  // Directed zone probes with 1:1 bounds: x, y, status screen flag.
  // Each sits on a zone edge, one either side where it matters.
  int zone_probe [10][3] = '{
    '{111, 266, 1}, '{112, 319, 1}, '{336, 266, 1}, '{0,   265, 1},
    '{355, 80,  0}, '{355, 81,  0}, '{119, 234, 0}, '{120, 319, 0},
    '{359, 250, 0}, '{360, 300, 0}
  };

  // Linear map of one raw axis through its two bounds, truncating toward
  // zero, then clamped to the screen. A zero span maps to the origin.
  function automatic logic [COORD_W-1:0] scale_axis(input logic [RAW_W-1:0] raw,
                                                    input logic [CFG_W-1:0] lo_r,
                                                    input logic [CFG_W-1:0] hi_r,
                                                    input longint span);
    longint lo;
    longint hi;
    longint pos;
    lo = $signed(lo_r);
    hi = $signed(hi_r);
    if (lo == hi) return '0;
    pos = (longint'(raw) - lo) * span / (hi - lo);
    if (pos < 0) pos = 0;
    if (pos > span) pos = span;
    return COORD_W'(pos);
  endfunction

  function automatic action_e zone_of(input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input bit on_status);
    if (on_status) begin
      if (y < ST_ROW) return ACT_NONE;
      if (x < ST_COL_A) return ACT_DASHBOARD;
      if (x < ST_COL_B) return ACT_CALIBRATE;
      return ACT_CLK_FMT;
    end
    if (y <= HDR_ROW && x >= HDR_COL) return ACT_STATUS;
    if (y >= RNG_TOP && y <= RNG_BOT) begin
      if (x < RNG_COL_A) return ACT_RANGE_3H;
      if (x < RNG_COL_B) return ACT_RANGE_6H;
      if (x < RNG_COL_C) return ACT_RANGE_12H;
      return ACT_RANGE_24H;
    end
    return ACT_NONE;
  endfunction

  // Advance the predicted state by one accepted request and queue its outcome.
  // Only a rising edge outside the hold-off window latches a new point;
  // a rejected edge leaves the latch open so a later held sample may win.
  task automatic predict_touch(input sample_t s);
    result_t r;
    r.action         = ACT_NONE;
    r.press_accepted = 1'b0;
    if (s.touch_down && !pressed) begin
      if (TIME_W'(s.time_ms - last_press_ms) >= TIME_W'(HOLD_OFF_MS)) begin
        last_press_ms    = s.time_ms;
        pressed          = 1'b1;
        held_x           = scale_axis(s.raw_x, cal_reg[CFG_X_LEFT], cal_reg[CFG_X_RIGHT],
                                      X_SPAN);
        held_y           = scale_axis(s.raw_y, cal_reg[CFG_Y_TOP], cal_reg[CFG_Y_BOTTOM],
                                      Y_SPAN);
        r.action         = zone_of(held_x, held_y, s.on_status_screen);
        r.press_accepted = 1'b1;
      end
    end else if (!s.touch_down) begin
      pressed = 1'b0;
    end
    r.screen_x = held_x[SCR_W-1:0];
    r.screen_y = held_y[SCR_W-1:0];
    outcome_fifo.push_back(r);
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    n_mismatch++;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    n_results++;
    if (outcome_fifo.size() == 0) begin
      report_mismatch($sformatf("result %0d with nothing outstanding: %h", n_results, got));
      return;
    end
    want = outcome_fifo.pop_front();
    if (got.action !== want.action)
      report_mismatch($sformatf("result %0d action %0d, want %0d",
                                n_results, got.action, want.action));
    if (got.press_accepted !== want.press_accepted)
      report_mismatch($sformatf("result %0d press_accepted %0b, want %0b",
                                n_results, got.press_accepted, want.press_accepted));
    if (got.screen_x !== want.screen_x)
      report_mismatch($sformatf("result %0d screen_x %0d, want %0d",
                                n_results, got.screen_x, want.screen_x));
    if (got.screen_y !== want.screen_y)
      report_mismatch($sformatf("result %0d screen_y %0d, want %0d",
                                n_results, got.screen_y, want.screen_y));
  endtask

  // Sender: holds a request until taken, otherwise pulls the next one unless
  // it rolls an idle cycle. Prediction runs on the request as it is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp.valid <= 1'b0;
    end else begin
      if (smp.valid && smp.ready) predict_touch(smp.data);
      if (!smp.valid || smp.ready) begin
        if (touch_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          smp.valid <= 1'b1;
          smp.data  <= touch_fifo.pop_front();
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result taken and throttles ready. The watchdog sits
  // last so nothing follows its finish.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) check_result(res.data);
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((smp.valid && smp.ready) || (res.valid && res.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(9))
      0:       return '0;
      1:       return {RAW_W{1'b1}};
      default: return RAW_W'($urandom_range(4095));
    endcase
  endfunction

  task automatic queue_touch(input bit down, input logic [RAW_W-1:0] rx,
                             input logic [RAW_W-1:0] ry, input bit on_status);
    sample_t s;
    s.touch_down       = down;
    s.raw_x            = rx;
    s.raw_y            = ry;
    s.time_ms          = gen_ms;
    s.on_status_screen = on_status;
    touch_fifo.push_back(s);
    n_queued++;
  endtask

  // Release, touch-down, then up to two held samples. The touch-down gap is taken
  // from the previous touch-down: mostly clear of the hold-off, sometimes
  // inside it, sometimes right on its edge.
  task automatic queue_press_run();
    int unsigned pick;
    int unsigned gap;
    int unsigned elapsed;
    gen_ms += $urandom_range(20, 1);
    queue_touch(1'b0, rand_raw(), rand_raw(), 1'($urandom_range(1)));
    elapsed = gen_ms - press_ms;
    pick    = $urandom_range(99);
    if (pick < 15)      gap = $urandom_range(179, 0);
    else if (pick < 30) gap = $urandom_range(182, 178);
    else                gap = $urandom_range(2000, 180);
    if (gap <= elapsed) gap = elapsed + 1;
    gen_ms   = press_ms + gap;
    press_ms = gen_ms;
    queue_touch(1'b1, rand_raw(), rand_raw(), 1'($urandom_range(1)));
    repeat ($urandom_range(2)) begin
      gen_ms += $urandom_range(60, 0);
      queue_touch(1'b1, rand_raw(), rand_raw(), 1'($urandom_range(1)));
    end
  endtask

  // Register writes happen only with the block drained; the shadow copy is
  // updated alongside so the next request sees the new bounds.
  task automatic write_cal(input cfg_idx_e idx, input int value);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_idx_i    <= idx;
    cfg_data_i   <= CFG_W'(value);
    cal_reg[idx]  = CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_bounds(input int x_left, input int x_right,
                            input int y_top, input int y_bottom);
    write_cal(CFG_X_LEFT, x_left);
    write_cal(CFG_X_RIGHT, x_right);
    write_cal(CFG_Y_TOP, y_top);
    write_cal(CFG_Y_BOTTOM, y_bottom);
  endtask

  // Polled on the falling edge so every queue and valid has settled.
  task automatic wait_drained();
    @(negedge clk_i);
    while (touch_fifo.size() != 0 || smp.valid || outcome_fifo.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned target;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_X_LEFT;
    cfg_data_i    = '0;
    smp.valid     = 1'b0;
    smp.data      = '0;
    res.ready     = 1'b0;
    cal_reg[CFG_X_LEFT]   = CFG_W'(0);
    cal_reg[CFG_X_RIGHT]  = CFG_W'(4095);
    cal_reg[CFG_Y_TOP]    = CFG_W'(0);
    cal_reg[CFG_Y_BOTTOM] = CFG_W'(4095);
    pressed       = 1'b0;
    last_press_ms = '0;
    held_x        = '0;
    held_y        = '0;
    gen_ms        = '0;
    press_ms      = '0;
    n_queued      = 0;
    n_results     = 0;
    n_mismatch    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 31;
    recv_idle_pct = 67;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Bounds of 0..479 and 0..319 make raw equal screen, so
    // zone edges can be hit exactly.
    set_bounds(0, 479, 0, 319);
    // Touch-down 179 ms after reset falls inside the hold-off; the same held
    // contact 1 ms later gets through, full-scale raw clamps to the corner.
    gen_ms = 32'd179;
    queue_touch(1'b1, '0, '0, 1'b0);
    gen_ms = 32'd180;
    queue_touch(1'b1, {RAW_W{1'b1}}, {RAW_W{1'b1}}, 1'b1);
    gen_ms = 32'd400;
    queue_touch(1'b1, RAW_W'(5), RAW_W'(5), 1'b0);
    for (int i = 0; i < 10; i++) begin
      gen_ms += 10;
      queue_touch(1'b0, RAW_W'(7), RAW_W'(7), 1'b0);
      gen_ms += 190;
      queue_touch(1'b1, RAW_W'(zone_probe[i][0]), RAW_W'(zone_probe[i][1]),
                  zone_probe[i][2] != 0);
    end
    press_ms = gen_ms;
    wait_drained();

    // Random phases, each under its own bounds and idling mix.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       set_bounds(0, 4095, 0, 4095);
        1:       set_bounds(4095, 0, 4095, 0);           // mirrored axes
        2:       set_bounds(100, 100, -5, -5);           // zero spans
        3:       set_bounds(-8192, 8191, 8191, -8192);   // widest codes
        4:       set_bounds(2000, 2001, 1000, 1003);     // tiny spans, heavy clamp
        5:       set_bounds(300, 3800, 250, 3900);       // a typical panel
        6:       set_bounds(int'($urandom_range(12287)) - 4096,
                            int'($urandom_range(12287)) - 4096,
                            int'($urandom_range(12287)) - 4096,
                            int'($urandom_range(12287)) - 4096);
        default: set_bounds(int'($urandom_range(16383)), int'($urandom_range(16383)),
                            int'($urandom_range(16383)), int'($urandom_range(16383)));
      endcase
      if (ph < 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 67;
      end else if (ph < 6) begin
        send_idle_pct = 67;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Fresh time base, often just short of the 32-bit wrap.
      if ($urandom_range(1)) gen_ms = $urandom();
      else gen_ms = 32'hFFFF_FFFF - $urandom_range(3000);
      press_ms = gen_ms;
      target   = n_queued + RUN_ITEMS;
      while (n_queued < target) begin
        if ($urandom_range(4) == 0) begin
          // noise: any flag, any reading, time stepping or jumping anywhere
          if ($urandom_range(3) == 0) gen_ms = $urandom();
          else gen_ms += $urandom_range(400, 0);
          queue_touch(1'($urandom_range(1)), rand_raw(), rand_raw(),
                      1'($urandom_range(1)));
        end else begin
          queue_press_run();
        end
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (outcome_fifo.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", outcome_fifo.size()));
    if (n_mismatch == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tmhc_pkg.sv
design/tmhc_if.sv
design/tmhc_axis.sv
design/tmhc_zone.sv
design/touch_map_and_hit_classifier.sv
design/tmhc_checker.sv
sim/touch_map_and_hit_classifier_tb.sv
